// ===== rtl/sro_pkg.sv =====
package sro_pkg;

    localparam int NUM_REGIONS = 5;
    localparam int REG_IDX_W   = 3;
    localparam int DIST_W      = 15;
    localparam int RANGE_W     = 16;
    localparam int MAG_W       = 17;
    localparam int LIN_W       = 12;
    localparam int ANG_W       = 14;
    localparam int CODE_W      = 4;
    localparam int SPR_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    typedef logic [DIST_W-1:0] t_dist;

    localparam logic [SPR_W-1:0] SPR_RESET       = 9'd72;
    localparam t_dist            CLAMP_RESET     = 15'd10000;
    localparam t_dist            FRONT_THR_RESET = 15'd750;
    localparam t_dist            RIGHT_THR_RESET = 15'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPR       = 2'd0,
        CFG_CLAMP     = 2'd1,
        CFG_FRONT_THR = 2'd2,
        CFG_RIGHT_THR = 2'd3
    } t_cfg_reg;

    typedef enum logic [CODE_W-1:0] {
        CASE_CLEAR        = 4'd0,
        CASE_FRONT        = 4'd1,
        CASE_FRIGHT       = 4'd2,
        CASE_FLEFT        = 4'd3,
        CASE_FRONT_FRIGHT = 4'd4,
        CASE_FRONT_FLEFT  = 4'd5,
        CASE_ALL          = 4'd6,
        CASE_FLEFT_FRIGHT = 4'd7,
        CASE_UNKNOWN      = 4'd8
    } t_case;

    localparam logic signed [LIN_W-1:0] LIN_STOP   = 12'sd0;
    localparam logic signed [LIN_W-1:0] LIN_CRUISE = -12'sd600;
    localparam logic signed [LIN_W-1:0] LIN_ESCAPE = -12'sd2000;
    localparam logic signed [ANG_W-1:0] ANG_NONE   = 14'sd0;
    localparam logic signed [ANG_W-1:0] ANG_LEFT   = 14'sd2000;
    localparam logic signed [ANG_W-1:0] ANG_RIGHT  = -14'sd2000;
    localparam logic signed [ANG_W-1:0] ANG_ESCAPE = 14'sd5000;

    typedef struct packed {
        logic signed [LIN_W-1:0] linear;
        logic signed [ANG_W-1:0] angular;
        t_case                   code;
        t_dist [NUM_REGIONS-1:0] minima;
    } t_result;

    function automatic t_case classify(input t_dist fr, input t_dist fc, input t_dist fl,
                                       input t_dist fthr, input t_dist rthr);
        logic f_hi, f_lo, l_hi, l_lo, r_hi, r_lo;
        t_case c;
        f_hi = fc > fthr;
        f_lo = fc < fthr;
        l_hi = fl > fthr;
        l_lo = fl < fthr;
        r_hi = fr > rthr;
        r_lo = fr < rthr;
        if      (f_hi && l_hi && r_hi) c = CASE_CLEAR;
        else if (f_lo && l_hi && r_hi) c = CASE_FRONT;
        else if (f_hi && l_hi && r_lo) c = CASE_FRIGHT;
        else if (f_hi && l_lo && r_hi) c = CASE_FLEFT;
        else if (f_lo && l_hi && r_lo) c = CASE_FRONT_FRIGHT;
        else if (f_lo && l_lo && r_hi) c = CASE_FRONT_FLEFT;
        else if (f_lo && l_lo && r_lo) c = CASE_ALL;
        else if (f_hi && l_lo && r_lo) c = CASE_FLEFT_FRIGHT;
        else                           c = CASE_UNKNOWN;
        return c;
    endfunction

    function automatic logic signed [LIN_W-1:0] linear_of(input t_case c);
        logic signed [LIN_W-1:0] v;
        case (c)
            CASE_CLEAR:        v = LIN_CRUISE;
            CASE_FLEFT_FRIGHT: v = LIN_ESCAPE;
            default:           v = LIN_STOP;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] angular_of(input t_case c);
        logic signed [ANG_W-1:0] v;
        case (c)
            CASE_FRONT, CASE_FRIGHT, CASE_FRONT_FRIGHT, CASE_ALL: v = ANG_LEFT;
            CASE_FLEFT, CASE_FRONT_FLEFT:                         v = ANG_RIGHT;
            CASE_FLEFT_FRIGHT:                                    v = ANG_ESCAPE;
            default:                                              v = ANG_NONE;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sro_in_if.sv =====
interface sro_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sro_pkg::RANGE_W-1:0]  range_mm;
    logic                                end_of_scan;

    modport source (output valid, output range_mm, output end_of_scan, input ready);
    modport sink   (input valid, input range_mm, input end_of_scan, output ready);
endinterface

// ===== rtl/sro_out_if.sv =====
interface sro_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sro_pkg::LIN_W-1:0]  linear_velocity;
    logic signed [sro_pkg::ANG_W-1:0]  angular_velocity;
    logic [sro_pkg::CODE_W-1:0]        case_code;
    logic [sro_pkg::DIST_W-1:0]        right_min;
    logic [sro_pkg::DIST_W-1:0]        front_right_min;
    logic [sro_pkg::DIST_W-1:0]        front_min;
    logic [sro_pkg::DIST_W-1:0]        front_left_min;
    logic [sro_pkg::DIST_W-1:0]        left_min;

    modport source (output valid, output linear_velocity, output angular_velocity,
                    output case_code, output right_min, output front_right_min,
                    output front_min, output front_left_min, output left_min,
                    input ready);
    modport sink   (input valid, input linear_velocity, input angular_velocity,
                    input case_code, input right_min, input front_right_min,
                    input front_min, input front_left_min, input left_min,
                    output ready);
endinterface

// ===== rtl/sro_cfg_if.sv =====
interface sro_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sro_pkg::CFG_IDX_W-1:0]       index;
    logic [sro_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/scan_region_obstacle_avoider.sv =====
// On end_of_scan the result goes to the output register, or skid entry if o_out stalls.
// Throughput: one range word per cycle unless i_in stalls; minima update on acceptance.
// Output register plus one skid entry; i_in stalls only while the skid entry is full.
// Reset (synchronous, active low): registers to reset values, minima to 10000,
// counters to zero, no result pending. Config port is always ready.
module scan_region_obstacle_avoider #(
    parameter int MAX_REGION_SAMPLES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sro_in_if.sink       i_in,
    sro_cfg_if.sink      i_cfg,
    sro_out_if.source    o_out
);

    localparam int LEN_W = $clog2(MAX_REGION_SAMPLES + 1);
    localparam int CMP_W = (LEN_W > sro_pkg::SPR_W) ? LEN_W : sro_pkg::SPR_W;

    logic [sro_pkg::SPR_W-1:0]  r_spr;
    sro_pkg::t_dist             r_clamp;
    sro_pkg::t_dist             r_fthr;
    sro_pkg::t_dist             r_rthr;

    sro_pkg::t_dist             r_min [sro_pkg::NUM_REGIONS];
    sro_pkg::t_dist             n_min [sro_pkg::NUM_REGIONS];
    logic [LEN_W-1:0]           r_cnt;
    logic [LEN_W-1:0]           n_cnt;
    logic [sro_pkg::REG_IDX_W-1:0] r_region;
    logic [sro_pkg::REG_IDX_W-1:0] n_region;

    sro_pkg::t_result           r_out;
    sro_pkg::t_result           r_skid;
    logic                       r_out_valid;
    logic                       r_skid_valid;

    logic                       w_in_fire;
    logic                       w_out_fire;
    logic                       w_emit;
    logic                       w_active;
    logic [sro_pkg::MAG_W-1:0]  w_mag;
    sro_pkg::t_dist             w_sample;
    logic [CMP_W-1:0]           w_spr;
    logic [CMP_W-1:0]           w_max;
    logic [CMP_W-1:0]           w_len;
    logic [CMP_W-1:0]           w_cnt_inc;
    sro_pkg::t_case             w_code;
    sro_pkg::t_result           w_result;

    assign i_in.ready  = !r_skid_valid;
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_fire  = r_out_valid && o_out.ready;
    assign w_emit      = w_in_fire && i_in.end_of_scan;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr   <= sro_pkg::SPR_RESET;
            r_clamp <= sro_pkg::CLAMP_RESET;
            r_fthr  <= sro_pkg::FRONT_THR_RESET;
            r_rthr  <= sro_pkg::RIGHT_THR_RESET;
        end else if (i_cfg.valid) begin
            case (sro_pkg::t_cfg_reg'(i_cfg.index))
                sro_pkg::CFG_SPR:       r_spr   <= i_cfg.data[sro_pkg::SPR_W-1:0];
                sro_pkg::CFG_CLAMP:     r_clamp <= i_cfg.data;
                sro_pkg::CFG_FRONT_THR: r_fthr  <= i_cfg.data;
                sro_pkg::CFG_RIGHT_THR: r_rthr  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // magnitude, clamp, region length
    always_comb begin
        if (i_in.range_mm[sro_pkg::RANGE_W-1]) begin
            w_mag = 17'h10000 - {1'b0, i_in.range_mm};
        end else begin
            w_mag = {1'b0, i_in.range_mm};
        end
        if (w_mag > {2'b00, r_clamp}) begin
            w_sample = r_clamp;
        end else begin
            w_sample = w_mag[sro_pkg::DIST_W-1:0];
        end

        w_spr = CMP_W'(r_spr);
        w_max = CMP_W'(MAX_REGION_SAMPLES);
        if (w_spr == '0) begin
            w_len = CMP_W'(1);
        end else if (w_spr > w_max) begin
            w_len = w_max;
        end else begin
            w_len = w_spr;
        end
        w_cnt_inc = CMP_W'(r_cnt) + CMP_W'(1);
        w_active  = r_region < sro_pkg::REG_IDX_W'(sro_pkg::NUM_REGIONS);
    end

    // running minima and counters
    always_comb begin
        n_cnt    = r_cnt;
        n_region = r_region;
        for (int k = 0; k < sro_pkg::NUM_REGIONS; k++) begin
            if (w_active && (r_region == sro_pkg::REG_IDX_W'(k)) && (w_sample < r_min[k])) begin
                n_min[k] = w_sample;
            end else begin
                n_min[k] = r_min[k];
            end
        end
        if (w_active) begin
            if (w_cnt_inc >= w_len) begin
                n_cnt    = '0;
                n_region = r_region + sro_pkg::REG_IDX_W'(1);
            end else begin
                n_cnt    = w_cnt_inc[LEN_W-1:0];
            end
        end
    end

    always_comb begin
        w_code           = sro_pkg::classify(n_min[1], n_min[2], n_min[3], r_fthr, r_rthr);
        w_result.linear  = sro_pkg::linear_of(w_code);
        w_result.angular = sro_pkg::angular_of(w_code);
        w_result.code    = w_code;
        for (int k = 0; k < sro_pkg::NUM_REGIONS; k++) begin
            w_result.minima[k] = n_min[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sro_pkg::NUM_REGIONS; k++) begin
                r_min[k] <= sro_pkg::CLAMP_RESET;
            end
            r_cnt    <= '0;
            r_region <= '0;
        end else if (w_in_fire) begin
            if (i_in.end_of_scan) begin
                for (int k = 0; k < sro_pkg::NUM_REGIONS; k++) begin
                    r_min[k] <= r_clamp;
                end
                r_cnt    <= '0;
                r_region <= '0;
            end else begin
                for (int k = 0; k < sro_pkg::NUM_REGIONS; k++) begin
                    r_min[k] <= n_min[k];
                end
                r_cnt    <= n_cnt;
                r_region <= n_region;
            end
        end
    end

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_fire) begin
            r_out_valid  <= r_skid_valid || w_emit;
            r_skid_valid <= 1'b0;
        end else if (w_emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_emit) begin
                r_out <= w_result;
            end
        end else if (w_emit) begin
            r_skid <= w_result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.linear_velocity  = r_out.linear;
    assign o_out.angular_velocity = r_out.angular;
    assign o_out.case_code        = r_out.code;
    assign o_out.right_min        = r_out.minima[0];
    assign o_out.front_right_min  = r_out.minima[1];
    assign o_out.front_min        = r_out.minima[2];
    assign o_out.front_left_min   = r_out.minima[3];
    assign o_out.left_min         = r_out.minima[4];

endmodule

// ===== rtl/sro_checker.sv =====
module sro_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_in_end_of_scan,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [sro_pkg::LIN_W-1:0]  i_out_linear,
    input logic signed [sro_pkg::ANG_W-1:0]  i_out_angular,
    input logic [sro_pkg::CODE_W-1:0]        i_out_code
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_linear) && $stable(i_out_angular)
            && $stable(i_out_code))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a mid-scan word never creates a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_end_of_scan && !i_out_valid |=> !i_out_valid)
        else $error("result without end of scan");

    a_unknown_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_code == sro_pkg::CASE_UNKNOWN) |->
            (i_out_linear == sro_pkg::LIN_STOP) && (i_out_angular == sro_pkg::ANG_NONE))
        else $error("unknown case with motion");

    a_clear_cruise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_code == sro_pkg::CASE_CLEAR) |->
            (i_out_linear == sro_pkg::LIN_CRUISE) && (i_out_angular == sro_pkg::ANG_NONE))
        else $error("clear case with wrong motion");

endmodule

bind scan_region_obstacle_avoider sro_checker u_sro_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_end_of_scan (i_in.end_of_scan),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_linear     (o_out.linear_velocity),
    .i_out_angular    (o_out.angular_velocity),
    .i_out_code       (o_out.case_code)
);

// ===== bench/scan_region_obstacle_avoider_test.sv =====
module scan_region_obstacle_avoider_test;
    import sro_pkg::*;

    localparam int REGION_CAP     = 256;
    localparam int RANDOM_WORDS   = 900;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [RANGE_W-1:0] range_mm;
        logic                      end_of_scan;
    } t_scan_word;

    typedef struct packed {
        logic signed [LIN_W-1:0] lin;
        logic signed [ANG_W-1:0] ang;
        t_case                   code;
        t_dist [NUM_REGIONS-1:0] mins;
    } t_motion_cmd;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sro_in_if  scan_in ();
    sro_cfg_if cfg_bus ();
    sro_out_if cmd_out ();

    scan_region_obstacle_avoider #(
        .MAX_REGION_SAMPLES(REGION_CAP)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (scan_in),
        .i_cfg  (cfg_bus),
        .o_out  (cmd_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [SPR_W-1:0] spr_reg       = SPR_RESET;
    t_dist            clamp_reg     = CLAMP_RESET;
    t_dist            front_thr_reg = FRONT_THR_RESET;
    t_dist            right_thr_reg = RIGHT_THR_RESET;
    t_dist            region_min [NUM_REGIONS];
    int               samples_seen;
    int               region_at;

    t_scan_word  scan_words [$];
    t_motion_cmd pending_cmds [$];
    int          words_sent  = 0;
    int          words_done  = 0;
    int          fail_count  = 0;
    int          idle_cycles = 0;

    t_scan_word  next_word;
    int          burst_left = 0;
    int          gap_left   = 0;

    t_motion_cmd want;
    logic [7:0]  ready_pat = 8'hFF;
    int          pat_pos   = 0;
    int          pat_span  = 0;

    function automatic int region_len();
        int n;
        n = spr_reg;
        if (n == 0) n = 1;
        if (n > REGION_CAP) n = REGION_CAP;
        return n;
    endfunction

    function automatic void restart_regions();
        for (int r = 0; r < NUM_REGIONS; r++) region_min[r] = clamp_reg;
        samples_seen = 0;
        region_at    = 0;
    endfunction

    task automatic absorb_word(input logic signed [RANGE_W-1:0] r, input logic eos);
        logic [MAG_W-1:0] mag;
        t_motion_cmd      cmd;
        t_dist            fr, fc, fl;
        mag = r[RANGE_W-1] ? (17'h10000 - {1'b0, r}) : {1'b0, r};
        if (mag > {2'b00, clamp_reg}) mag = {2'b00, clamp_reg};
        if (region_at < NUM_REGIONS) begin
            if (mag < {2'b00, region_min[region_at]}) region_min[region_at] = mag[DIST_W-1:0];
            samples_seen++;
            if (samples_seen >= region_len()) begin
                samples_seen = 0;
                region_at++;
            end
        end
        if (eos) begin
            fr = region_min[1];
            fc = region_min[2];
            fl = region_min[3];
            if (fc == front_thr_reg || fl == front_thr_reg || fr == right_thr_reg) begin
                cmd.code = CASE_UNKNOWN;
            end else begin
                case ({fc < front_thr_reg, fl < front_thr_reg, fr < right_thr_reg})
                    3'b000: cmd.code = CASE_CLEAR;
                    3'b100: cmd.code = CASE_FRONT;
                    3'b001: cmd.code = CASE_FRIGHT;
                    3'b010: cmd.code = CASE_FLEFT;
                    3'b101: cmd.code = CASE_FRONT_FRIGHT;
                    3'b110: cmd.code = CASE_FRONT_FLEFT;
                    3'b111: cmd.code = CASE_ALL;
                    default: cmd.code = CASE_FLEFT_FRIGHT;
                endcase
            end
            case (cmd.code)
                CASE_CLEAR: begin
                    cmd.lin = LIN_CRUISE;
                    cmd.ang = ANG_NONE;
                end
                CASE_FRONT, CASE_FRIGHT, CASE_FRONT_FRIGHT, CASE_ALL: begin
                    cmd.lin = LIN_STOP;
                    cmd.ang = ANG_LEFT;
                end
                CASE_FLEFT, CASE_FRONT_FLEFT: begin
                    cmd.lin = LIN_STOP;
                    cmd.ang = ANG_RIGHT;
                end
                CASE_FLEFT_FRIGHT: begin
                    cmd.lin = LIN_ESCAPE;
                    cmd.ang = ANG_ESCAPE;
                end
                default: begin
                    cmd.lin = LIN_STOP;
                    cmd.ang = ANG_NONE;
                end
            endcase
            for (int r = 0; r < NUM_REGIONS; r++) cmd.mins[r] = region_min[r];
            pending_cmds.push_back(cmd);
            restart_regions();
        end
    endtask

    function automatic void check_field(input string name, input logic signed [31:0] exp_v,
                                        input logic signed [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // word driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_in.valid       <= 1'b0;
            scan_in.range_mm    <= '0;
            scan_in.end_of_scan <= 1'b0;
        end else begin
            if (scan_in.valid && scan_in.ready) begin
                absorb_word(scan_in.range_mm, scan_in.end_of_scan);
                words_done++;
            end
            if (!scan_in.valid || scan_in.ready) begin
                if (gap_left > 0 || scan_words.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    scan_in.valid <= 1'b0;
                end else begin
                    next_word = scan_words.pop_front();
                    scan_in.valid       <= 1'b1;
                    scan_in.range_mm    <= next_word.range_mm;
                    scan_in.end_of_scan <= next_word.end_of_scan;
                    if (burst_left == 0) burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // command monitor with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_out.ready <= 1'b0;
            pat_span = 0;
        end else begin
            if (cmd_out.valid && cmd_out.ready) begin
                if (pending_cmds.size() == 0) begin
                    $error("command word with nothing expected");
                    fail_count++;
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("linear_velocity", want.lin, cmd_out.linear_velocity);
                    check_field("angular_velocity", want.ang, cmd_out.angular_velocity);
                    check_field("case_code", want.code, cmd_out.case_code);
                    check_field("right_min", want.mins[0], cmd_out.right_min);
                    check_field("front_right_min", want.mins[1], cmd_out.front_right_min);
                    check_field("front_min", want.mins[2], cmd_out.front_min);
                    check_field("front_left_min", want.mins[3], cmd_out.front_left_min);
                    check_field("left_min", want.mins[4], cmd_out.left_min);
                end
            end
            if (pat_span == 0) begin
                pat_span = $urandom_range(16, 96);
                case ($urandom_range(0, 2))
                    0: ready_pat = 8'hFF;
                    1: ready_pat = 8'($urandom) | 8'h01;
                    default: ready_pat = 8'h01;
                endcase
            end
            pat_span--;
            cmd_out.ready <= ready_pat[pat_pos];
            pat_pos = (pat_pos + 1) % 8;
        end
    end

    always @(posedge i_clk) begin
        if ((scan_in.valid && scan_in.ready) || (cmd_out.valid && cmd_out.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("scan_region_obstacle_avoider_test: errors");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        data = value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_SPR:       spr_reg       = data[SPR_W-1:0];
            CFG_CLAMP:     clamp_reg     = data;
            CFG_FRONT_THR: front_thr_reg = data;
            default:       right_thr_reg = data;
        endcase
    endtask

    task automatic set_config(input int spr_v, input int clamp_v, input int fthr_v,
                              input int rthr_v);
        write_reg(CFG_SPR, spr_v);
        write_reg(CFG_CLAMP, clamp_v);
        write_reg(CFG_FRONT_THR, fthr_v);
        write_reg(CFG_RIGHT_THR, rthr_v);
    endtask

    task automatic queue_word(input int r, input logic eos);
        t_scan_word w;
        w.range_mm    = RANGE_W'(r);
        w.end_of_scan = eos;
        scan_words.push_back(w);
        words_sent++;
    endtask

    // wait for every word taken and every command seen, then let the pipe empty
    task automatic settle();
        @(posedge i_clk);
        while (words_done != words_sent || pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [RANGE_W-1:0] pick_range();
        int v, sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) v = int'(front_thr_reg) + $urandom_range(0, 6) - 3;
        else if (sel < 40) v = int'(right_thr_reg) + $urandom_range(0, 6) - 3;
        else if (sel < 48) v = int'(clamp_reg) + $urandom_range(0, 6) - 3;
        else if (sel < 56) begin
            case ($urandom_range(0, 4))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                3: v = -1;
                default: v = 1;
            endcase
        end else v = int'($urandom_range(0, 65535)) - 32768;
        if (sel < 48 && $urandom_range(0, 1) == 1) v = -v;
        return RANGE_W'(v);
    endfunction

    task automatic queue_scan(input int n);
        for (int i = 0; i < n; i++) queue_word(pick_range(), i == n - 1);
    endtask

    task automatic run_phase(input int budget);
        int len, n, sel, pushed, scans;
        len    = region_len();
        pushed = 0;
        scans  = 0;
        if (len > 16) begin
            queue_scan($urandom_range(len + 1, 2 * len - 1));
            queue_scan($urandom_range(1, 12));
        end else begin
            while (pushed < budget) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) n = NUM_REGIONS * len;
                else if (sel < 85) n = $urandom_range(1, NUM_REGIONS * len);
                else n = NUM_REGIONS * len + $urandom_range(1, 8);
                queue_scan(n);
                pushed += n;
                scans++;
                if (scans == 1 || $urandom_range(0, 9) == 0) settle();
            end
            // leave a scan open across the next register update
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, NUM_REGIONS * len);
                for (int i = 0; i < n; i++) queue_word(pick_range(), 1'b0);
            end
        end
        settle();
    endtask

    initial begin
        int random_start, k, sel;
        int spr_v, clamp_v, fthr_v, rthr_v;
        scan_in.valid       = 1'b0;
        scan_in.range_mm    = '0;
        scan_in.end_of_scan = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_SPR;
        cfg_bus.data        = '0;
        cmd_out.ready       = 1'b0;
        restart_regions();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of reset, all regions empty
        queue_word(32767, 1'b1);
        settle();

        // zero region length acts as one; front-right and front on their thresholds
        write_reg(CFG_SPR, 0);
        queue_word(-32768, 1'b0);
        queue_word(250, 1'b0);
        queue_word(750, 1'b0);
        queue_word(751, 1'b0);
        queue_word(0, 1'b1);
        settle();

        // all three front regions close, extra samples past the left region
        queue_word(1, 1'b0);
        queue_word(249, 1'b0);
        queue_word(749, 1'b0);
        queue_word(749, 1'b0);
        queue_word(32767, 1'b0);
        queue_word(0, 1'b0);
        queue_word(-1, 1'b1);
        settle();

        queue_word(5000, 1'b0);
        queue_word(251, 1'b0);
        queue_word(751, 1'b0);
        queue_word(751, 1'b0);
        queue_word(5000, 1'b1);
        settle();

        // clamp lowered in the middle of a scan
        write_reg(CFG_CLAMP, 5000);
        queue_word(20000, 1'b0);
        queue_word(20000, 1'b0);
        settle();
        write_reg(CFG_CLAMP, 300);
        queue_word(-20000, 1'b0);
        queue_word(100, 1'b0);
        queue_word(0, 1'b1);
        settle();

        random_start = words_sent;
        k = 0;
        while (words_sent - random_start < RANDOM_WORDS) begin
            case (k)
                0: begin spr_v = 1;   clamp_v = 10000; fthr_v = 750;   rthr_v = 250;   end
                1: begin spr_v = 3;   clamp_v = 10000; fthr_v = 750;   rthr_v = 250;   end
                2: begin spr_v = 0;   clamp_v = 10000; fthr_v = 750;   rthr_v = 250;   end
                3: begin spr_v = 2;   clamp_v = 32767; fthr_v = 32767; rthr_v = 32767; end
                4: begin spr_v = 4;   clamp_v = 32767; fthr_v = 0;     rthr_v = 0;     end
                5: begin spr_v = 1;   clamp_v = 0;     fthr_v = 0;     rthr_v = 0;     end
                6: begin spr_v = 513; clamp_v = 3000;  fthr_v = 750;   rthr_v = 250;   end
                7: begin spr_v = 511; clamp_v = 10000; fthr_v = 750;   rthr_v = 250;   end
                default: begin
                    sel = $urandom_range(0, 99);
                    if (sel < 60) spr_v = $urandom_range(1, 4);
                    else if (sel < 80) spr_v = $urandom_range(5, 10);
                    else if (sel < 90) spr_v = 0;
                    else spr_v = 512 + $urandom_range(1, 3);
                    sel = $urandom_range(0, 99);
                    if (sel < 50) clamp_v = $urandom_range(400, 12000);
                    else if (sel < 65) clamp_v = 32767;
                    else if (sel < 75) clamp_v = 0;
                    else clamp_v = $urandom_range(0, 32767);
                    sel = $urandom_range(0, 99);
                    if (sel < 70) fthr_v = $urandom_range(0, clamp_v);
                    else if (sel < 80) fthr_v = clamp_v;
                    else fthr_v = $urandom_range(0, 32767);
                    sel = $urandom_range(0, 99);
                    if (sel < 70) rthr_v = $urandom_range(0, clamp_v);
                    else if (sel < 80) rthr_v = clamp_v;
                    else rthr_v = $urandom_range(0, 32767);
                end
            endcase
            set_config(spr_v, clamp_v, fthr_v, rthr_v);
            run_phase($urandom_range(40, 90));
            k++;
        end

        if (fail_count == 0) $display("scan_region_obstacle_avoider_test: clean");
        else $display("scan_region_obstacle_avoider_test: errors");
        $finish;
    end

endmodule
